>>> hw/rtl/sole_pkg.sv
// Package for the sorted order list engine: widths, types, opcodes and status
// codes. No dependencies.
package sole_pkg;

  localparam int POOL_DEPTH = 64;
  localparam int SLOT_BITS  = $clog2(POOL_DEPTH + 1);
  localparam int ADDR_BITS  = $clog2(POOL_DEPTH);
  localparam int KEY_BITS   = 48;
  localparam int OWNER_BITS = 16;
  localparam int WALK_BITS  = $clog2(POOL_DEPTH + 1);

  typedef logic [SLOT_BITS-1:0]  slot_t;
  typedef logic [ADDR_BITS-1:0]  addr_t;
  typedef logic [KEY_BITS-1:0]   key_t;
  typedef logic [OWNER_BITS-1:0] owner_t;

  localparam logic [1:0] OP_ADD_FWD = 2'd0;
  localparam logic [1:0] OP_ADD_BWD = 2'd1;
  localparam logic [1:0] OP_UPDATE  = 2'd2;
  localparam logic [1:0] OP_REMOVE  = 2'd3;

  localparam logic [2:0] ST_OK        = 3'd0;
  localparam logic [2:0] ST_FULL      = 3'd1;
  localparam logic [2:0] ST_NOT_OWNER = 3'd2;
  localparam logic [2:0] ST_BAD_SLOT  = 3'd3;
  localparam logic [2:0] ST_REMOVED   = 3'd4;

  // One slot record as held in the node memory (data fields live apart).
  typedef struct packed {
    slot_t  prev;
    slot_t  next;
    key_t   key;
    owner_t owner;
    logic   live;
  } node_t;

  // Write request into the node memory.
  typedef struct packed {
    logic  we_prev;
    logic  we_next;
    logic  we_all;
    logic  we_live;
    addr_t addr;
    node_t data;
  } node_wr_t;

  function automatic addr_t slot_addr(slot_t s);
    slot_t t;
    t = s - slot_t'(1);
    return t[ADDR_BITS-1:0];
  endfunction

endpackage

>>> hw/rtl/sole_node_mem.sv
// Node memory: links, key, owner and live flag per slot, one write port and
// one registered read port. Uses sole_pkg.
module sole_node_mem (
  input  logic                clk,
  input  sole_pkg::node_wr_t  wr,
  input  logic                rd_en,
  input  sole_pkg::addr_t     rd_addr,
  output sole_pkg::node_t     rd_data
);

  sole_pkg::slot_t  prev_mem  [sole_pkg::POOL_DEPTH];
  sole_pkg::slot_t  next_mem  [sole_pkg::POOL_DEPTH];
  sole_pkg::key_t   key_mem   [sole_pkg::POOL_DEPTH];
  sole_pkg::owner_t owner_mem [sole_pkg::POOL_DEPTH];
  logic             live_mem  [sole_pkg::POOL_DEPTH];

  always_ff @(posedge clk) begin
    if (wr.we_prev || wr.we_all) prev_mem[wr.addr] <= wr.data.prev;
    if (wr.we_next || wr.we_all) next_mem[wr.addr] <= wr.data.next;
    if (wr.we_all) begin
      key_mem[wr.addr]   <= wr.data.key;
      owner_mem[wr.addr] <= wr.data.owner;
    end
    if (wr.we_live || wr.we_all) live_mem[wr.addr] <= wr.data.live;
    if (rd_en) begin
      rd_data.prev  <= prev_mem[rd_addr];
      rd_data.next  <= next_mem[rd_addr];
      rd_data.key   <= key_mem[rd_addr];
      rd_data.owner <= owner_mem[rd_addr];
      rd_data.live  <= live_mem[rd_addr];
    end
  end

endmodule

>>> hw/rtl/sole_data_mem.sv
// Data memory: stored price and amount per slot; write only, never read on
// the result path. Uses sole_pkg.
module sole_data_mem (
  input  logic             clk,
  input  logic             we,
  input  sole_pkg::addr_t  addr,
  input  logic [47:0]      price,
  input  logic [47:0]      amount
);

  logic [95:0] mem [sole_pkg::POOL_DEPTH];

  always_ff @(posedge clk) begin
    if (we) mem[addr] <= {amount, price};
  end

endmodule

>>> hw/rtl/sorted_order_list_engine_unit.sv
// Sorted order list engine: price-sorted doubly linked list in a slot pool.
// Full pool and bad slot requests go straight to the result; update and remove
// first read the slot record; an add walks the list (each walk step is one node
// memory read, then a compare), for at most POOL_DEPTH entries, then links in.
// One item at a time; in_tready is high in IDLE once the last result is taken.
// Reset (rst_n low, synchronous) empties the list: head, tail, count and the
// slot allocator clear; memory contents are left as they are.
module sorted_order_list_engine_unit (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_tvalid,
  output logic          in_tready,
  // tdata: opcode[1:0], slot_index[8:2], price[56:9], amount[104:57],
  // requester[120:105], zero fill to 128
  input  logic [127:0]  in_tdata,
  output logic          out_tvalid,
  input  logic          out_tready,
  // tdata: status[2:0], placed_slot[9:3], head_slot[16:10], tail_slot[23:17],
  // live_count[30:24], zero fill to 32
  output logic [31:0]   out_tdata
);

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_CHK   = 4'd1; // slot read issued for update/remove
  localparam logic [3:0] S_CHK2  = 4'd2; // slot record present
  localparam logic [3:0] S_WALK  = 4'd3; // node read issued
  localparam logic [3:0] S_CMP   = 4'd4; // node record present, compare
  localparam logic [3:0] S_NBR   = 4'd5; // spare cycle after a hit
  localparam logic [3:0] S_LINK  = 4'd6; // write the new node
  localparam logic [3:0] S_FIX1  = 4'd7; // patch one side
  localparam logic [3:0] S_FIX2  = 4'd8; // patch other side
  localparam logic [3:0] S_OUT   = 4'd9;

  logic [3:0] state_r, state_nxt;

  logic [1:0]        op_r;
  sole_pkg::slot_t   sidx_r;
  logic [47:0]       price_r, amount_r;
  sole_pkg::owner_t  req_r;

  sole_pkg::slot_t head_r, tail_r, total_r, used_r;
  sole_pkg::slot_t it_r, before_r, after_r;
  logic [sole_pkg::WALK_BITS-1:0] steps_r;
  logic [2:0] status_r;
  sole_pkg::slot_t placed_r;
  logic [31:0] out_data_r;
  logic        out_valid_r;

  sole_pkg::node_wr_t wr;
  logic               rd_en;
  sole_pkg::addr_t    rd_addr;
  sole_pkg::node_t    rd_data;

  sole_node_mem u_node (.clk, .wr, .rd_en, .rd_addr, .rd_data);
  sole_data_mem u_data (
    .clk, .we(wr.we_all || (state_r == S_CHK2 && op_r == sole_pkg::OP_UPDATE &&
              rd_data.live)),
    .addr(wr.we_all ? wr.addr : sole_pkg::slot_addr(sidx_r)),
    .price(price_r), .amount(amount_r)
  );

  logic fwd;
  logic it_ok;
  logic hit;
  sole_pkg::slot_t ns;
  assign fwd   = (op_r == sole_pkg::OP_ADD_FWD);
  assign ns    = used_r + sole_pkg::slot_t'(1);
  assign it_ok = (it_r != '0) && (it_r <= used_r) &&
                 (steps_r != sole_pkg::WALK_BITS'(sole_pkg::POOL_DEPTH));
  assign hit   = fwd ? (rd_data.key >= price_r[sole_pkg::KEY_BITS-1:0])
                     : (rd_data.key <= price_r[sole_pkg::KEY_BITS-1:0]);

  assign in_tready  = (state_r == S_IDLE) && !out_valid_r;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  always_comb begin
    state_nxt = state_r;
    rd_en     = 1'b0;
    rd_addr   = sole_pkg::slot_addr(it_r);
    wr        = '0;
    unique case (state_r)
      S_IDLE: if (in_tvalid && in_tready) state_nxt = S_CHK;
      S_CHK: begin
        if (op_r == sole_pkg::OP_ADD_FWD || op_r == sole_pkg::OP_ADD_BWD) begin
          state_nxt = (used_r == sole_pkg::slot_t'(sole_pkg::POOL_DEPTH)) ? S_OUT :
                      S_WALK;
        end else if (sidx_r == '0 || sidx_r > used_r) begin
          state_nxt = S_OUT;
        end else begin
          rd_en = 1'b1; rd_addr = sole_pkg::slot_addr(sidx_r);
          state_nxt = S_CHK2;
        end
      end
      S_CHK2: begin
        if (!rd_data.live || op_r == sole_pkg::OP_UPDATE ||
            rd_data.owner != req_r) state_nxt = S_OUT;
        else state_nxt = S_FIX1;
        if (rd_data.live && op_r == sole_pkg::OP_REMOVE && rd_data.owner == req_r) begin
          wr.we_live = 1'b1; wr.addr = sole_pkg::slot_addr(sidx_r);
          wr.data.live = 1'b0;
        end
      end
      S_WALK: begin
        if (it_ok) begin
          rd_en = 1'b1; state_nxt = S_CMP;
        end else state_nxt = S_LINK;
      end
      S_CMP: state_nxt = hit ? S_NBR : S_WALK;
      S_NBR: state_nxt = S_LINK;
      S_LINK: begin
        wr.we_all = 1'b1; wr.addr = sole_pkg::slot_addr(ns);
        wr.data.prev = before_r; wr.data.next = after_r;
        wr.data.key = price_r[sole_pkg::KEY_BITS-1:0];
        wr.data.owner = req_r; wr.data.live = 1'b1;
        state_nxt = S_FIX1;
      end
      S_FIX1: begin
        // before.next = new (add) or prev.next = next (remove)
        if (before_r != '0) begin
          wr.we_next = 1'b1; wr.addr = sole_pkg::slot_addr(before_r);
          wr.data.next = (op_r == sole_pkg::OP_REMOVE) ? after_r : placed_r;
        end
        state_nxt = S_FIX2;
      end
      S_FIX2: begin
        if (after_r != '0) begin
          wr.we_prev = 1'b1; wr.addr = sole_pkg::slot_addr(after_r);
          wr.data.prev = (op_r == sole_pkg::OP_REMOVE) ? before_r : placed_r;
        end
        state_nxt = S_OUT;
      end
      S_OUT: state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      head_r <= '0; tail_r <= '0; total_r <= '0; used_r <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      // raise the result beat in S_OUT, drop it once taken
      if (state_r == S_OUT) out_valid_r <= 1'b1;
      else if (out_valid_r && out_tready) out_valid_r <= 1'b0;
      unique case (state_r)
        S_IDLE: if (in_tvalid && in_tready) begin
          op_r     <= in_tdata[1:0];
          sidx_r   <= in_tdata[8:2];
          price_r  <= in_tdata[56:9];
          amount_r <= in_tdata[104:57];
          req_r    <= in_tdata[120:105];
          status_r <= sole_pkg::ST_OK;
          placed_r <= '0;
          steps_r  <= '0;
          it_r     <= (in_tdata[1:0] == sole_pkg::OP_ADD_FWD) ? head_r : tail_r;
        end
        S_CHK: begin
          if (op_r == sole_pkg::OP_ADD_FWD || op_r == sole_pkg::OP_ADD_BWD) begin
            if (used_r == sole_pkg::slot_t'(sole_pkg::POOL_DEPTH))
              status_r <= sole_pkg::ST_FULL;
          end else if (sidx_r == '0 || sidx_r > used_r) begin
            status_r <= sole_pkg::ST_BAD_SLOT;
          end
        end
        S_CHK2: begin
          before_r <= rd_data.prev;
          after_r  <= rd_data.next;
          if (!rd_data.live) status_r <= sole_pkg::ST_REMOVED;
          else if (op_r == sole_pkg::OP_REMOVE) begin
            if (rd_data.owner != req_r) status_r <= sole_pkg::ST_NOT_OWNER;
            else begin
              if (rd_data.prev == '0) head_r <= rd_data.next;
              if (rd_data.next == '0) tail_r <= rd_data.prev;
              if (total_r != '0) total_r <= total_r - sole_pkg::slot_t'(1);
            end
          end
        end
        S_WALK: if (!it_ok) begin
          // no match: add at head (forward) or tail (backward)
          before_r <= fwd ? '0 : tail_r;
          after_r  <= fwd ? head_r : '0;
        end
        S_CMP: begin
          steps_r <= steps_r + sole_pkg::WALK_BITS'(1);
          if (hit) begin
            before_r <= fwd ? rd_data.prev : it_r;
            after_r  <= fwd ? it_r : rd_data.next;
          end else it_r <= fwd ? rd_data.next : rd_data.prev;
        end
        S_LINK: begin
          used_r   <= ns;
          placed_r <= ns;
          total_r  <= total_r + sole_pkg::slot_t'(1);
          if (before_r == '0) head_r <= ns;
          if (after_r == '0) tail_r <= ns;
        end
        S_OUT: begin
          out_data_r  <= {1'b0, total_r, tail_r, head_r, placed_r, status_r};
        end
        default: ;
      endcase
    end
  end

  assert property (@(posedge clk) disable iff (!rst_n)
                   out_valid_r && !out_tready |=> out_valid_r)
    else $error("result beat dropped while stalled");
  assert property (@(posedge clk) disable iff (!rst_n) (state_r == S_OUT) |=> out_valid_r)
    else $error("result not raised");
  assert property (@(posedge clk) disable iff (!rst_n) (total_r <= used_r))
    else $error("count above allocated slots");
  assert property (@(posedge clk) disable iff (!rst_n) (state_r != S_IDLE) |-> !in_tready)
    else $error("input taken while busy");

endmodule

>>> sim/testbench.sv
// Testbench for sorted_order_list_engine_unit: drives order beats (adds, updates,
// removes), predicts each result beat from a behavioral copy of the order list.
// Depends on sole_pkg and the RTL top level only.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int WATCHDOG_LIMIT = 4000;
  localparam int DRAIN_CYCLES   = 2 * sole_pkg::POOL_DEPTH + 16;

  typedef struct packed {
    logic [15:0] requester;
    logic [47:0] amount;
    logic [47:0] price;
    logic [6:0]  slot_index;
    logic [1:0]  opcode;
  } order_req_t;

  typedef struct packed {
    logic [6:0] live_count;
    logic [6:0] tail_slot;
    logic [6:0] head_slot;
    logic [6:0] placed_slot;
    logic [2:0] status;
  } order_resp_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_tvalid = 1'b0;
  logic in_tready;
  logic [127:0] in_tdata = '0;
  logic out_tvalid;
  logic out_tready = 1'b0;
  logic [31:0] out_tdata;

  sorted_order_list_engine_unit u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),   // opcode, slot_index, price, amount, requester, zero fill
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata)   // status, placed_slot, head_slot, tail_slot, live_count
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Shadow copy of the order list.
  sole_pkg::slot_t   ol_prev  [1:sole_pkg::POOL_DEPTH];
  sole_pkg::slot_t   ol_next  [1:sole_pkg::POOL_DEPTH];
  sole_pkg::key_t    ol_key   [1:sole_pkg::POOL_DEPTH];
  sole_pkg::owner_t  ol_owner [1:sole_pkg::POOL_DEPTH];
  logic              ol_live  [1:sole_pkg::POOL_DEPTH];
  int      ol_head, ol_tail, ol_count, ol_used;

  order_req_t  pending_orders[$];
  order_resp_t expected_resps[$];
  bit          hold_for_drain[$];   // per beat: wait until all results are back first
  int          fail_count = 0;
  int          beats_in = 0, beats_out = 0, stall_cycles = 0;
  int          status_seen[5] = '{default: 0};

  function automatic bit slot_valid(int s);
    return s != 0 && s <= ol_used;
  endfunction

  // Walk for the anchor of an add; 0 when nothing qualifies.
  function automatic int find_anchor(bit fwd, sole_pkg::key_t k);
    int it, n;
    it = fwd ? ol_head : ol_tail;
    for (n = 0; n < sole_pkg::POOL_DEPTH && slot_valid(it); n++) begin
      if (fwd ? (ol_key[it] >= k) : (ol_key[it] <= k)) return it;
      it = fwd ? int'(ol_next[it]) : int'(ol_prev[it]);
    end
    return 0;
  endfunction

  function automatic void splice_in(int ns, int bef, int aft);
    ol_prev[ns] = sole_pkg::slot_t'(bef);
    ol_next[ns] = sole_pkg::slot_t'(aft);
    if (bef != 0) ol_next[bef] = sole_pkg::slot_t'(ns); else ol_head = ns;
    if (aft != 0) ol_prev[aft] = sole_pkg::slot_t'(ns); else ol_tail = ns;
  endfunction

  function automatic order_resp_t apply_order(order_req_t r);
    order_resp_t rs;
    int it, ns, s, p, n;
    rs = '0;
    rs.status = sole_pkg::ST_OK;
    s = int'(r.slot_index);
    if (r.opcode == sole_pkg::OP_ADD_FWD || r.opcode == sole_pkg::OP_ADD_BWD) begin
      if (ol_used >= sole_pkg::POOL_DEPTH) begin
        rs.status = sole_pkg::ST_FULL;
      end else begin
        it = find_anchor(r.opcode == sole_pkg::OP_ADD_FWD, r.price);
        ns = ol_used + 1;
        ol_used = ns;
        ol_key[ns] = r.price;
        ol_owner[ns] = r.requester;
        ol_live[ns] = 1'b1;
        if (r.opcode == sole_pkg::OP_ADD_FWD) begin
          if (it == 0) splice_in(ns, 0, ol_head);
          else splice_in(ns, int'(ol_prev[it]), it);
        end else begin
          if (it == 0) splice_in(ns, ol_tail, 0);
          else splice_in(ns, it, int'(ol_next[it]));
        end
        ol_count++;
        rs.placed_slot = 7'(ns);
      end
    end else if (!slot_valid(s)) begin
      rs.status = sole_pkg::ST_BAD_SLOT;
    end else if (!ol_live[s]) begin
      rs.status = sole_pkg::ST_REMOVED;
    end else if (r.opcode == sole_pkg::OP_UPDATE) begin
      // data fields are not visible at the outputs; key is untouched
    end else if (ol_owner[s] != r.requester) begin
      rs.status = sole_pkg::ST_NOT_OWNER;
    end else begin
      p = int'(ol_prev[s]);
      n = int'(ol_next[s]);
      if (p != 0) ol_next[p] = sole_pkg::slot_t'(n); else ol_head = n;
      if (n != 0) ol_prev[n] = sole_pkg::slot_t'(p); else ol_tail = p;
      ol_live[s] = 1'b0;
      if (ol_count != 0) ol_count--;
    end
    rs.head_slot = 7'(ol_head);
    rs.tail_slot = 7'(ol_tail);
    rs.live_count = 7'(ol_count);
    return rs;
  endfunction

  // Stimulus-side tracking so removes can name the right owner.
  int                gen_used;
  sole_pkg::owner_t  gen_owner[1:sole_pkg::POOL_DEPTH];

  function automatic logic [47:0] rand48();
    return 48'({$urandom(), $urandom()});
  endfunction

  function automatic logic [47:0] rand_price();
    logic [47:0] v;
    case ($urandom_range(0, 3))
      0: v = 48'(($urandom_range(0, 15)));   // tight range to force equal keys
      1: v = '1 - 48'($urandom_range(0, 3));
      default: v = rand48();
    endcase
    return v;
  endfunction

  task automatic queue_order(logic [1:0] op, int s, logic [47:0] pr, logic [47:0] am,
                             logic [15:0] rq, bit hold = 1'b0);
    order_req_t r;
    r.opcode = op;
    r.slot_index = 7'(s);
    r.price = pr;
    r.amount = am;
    r.requester = rq;
    if ((op == sole_pkg::OP_ADD_FWD || op == sole_pkg::OP_ADD_BWD) &&
        gen_used < sole_pkg::POOL_DEPTH) begin
      gen_used++;
      gen_owner[gen_used] = rq;
    end
    pending_orders = {pending_orders, r};
    hold_for_drain = {hold_for_drain, hold};
  endtask

  // Slot index for update/remove; stays within written slots unless out of range on purpose.
  function automatic int pick_slot();
    if (gen_used == 0 || $urandom_range(0, 15) == 0)
      return (gen_used == 0 || $urandom_range(0, 1)) ? 0 : $urandom_range(gen_used + 1, 127);
    return $urandom_range(1, gen_used);
  endfunction

  task automatic queue_session(int n_items);
    int k, s;
    logic [15:0] rq;
    for (k = 0; k < n_items; k++) begin
      s = pick_slot();
      case ($urandom_range(0, 9))
        0, 1, 2: queue_order(sole_pkg::OP_ADD_FWD, $urandom_range(0, 127), rand_price(),
                             rand48(), 16'($urandom()));
        3, 4, 5: queue_order(sole_pkg::OP_ADD_BWD, $urandom_range(0, 127), rand_price(),
                             rand48(), 16'($urandom()));
        6: queue_order(sole_pkg::OP_UPDATE, s, rand48(), rand48(), 16'($urandom()));
        default: begin
          // mostly the real owner, sometimes a stranger
          rq = (s >= 1 && s <= gen_used && $urandom_range(0, 3) != 0) ?
               gen_owner[s] : 16'($urandom());
          queue_order(sole_pkg::OP_REMOVE, s, rand48(), rand48(), rq);
        end
      endcase
    end
  endtask

  initial begin
    int k;
    gen_used = 0;
    // directed: bad slots on an empty pool, extremes of every field
    queue_order(sole_pkg::OP_UPDATE, 0, '0, '0, '0);
    queue_order(sole_pkg::OP_REMOVE, 127, '1, '1, '1);
    queue_order(sole_pkg::OP_ADD_FWD, 127, 48'd100, '1, 16'hFFFF);
    queue_order(sole_pkg::OP_ADD_FWD, 0, 48'd100, '0, 16'h0000);   // equal key, goes before
    queue_order(sole_pkg::OP_ADD_BWD, 0, 48'd100, 48'd5, 16'h1234); // equal key, goes after
    queue_order(sole_pkg::OP_ADD_FWD, 0, '1, 48'd1, 16'h0001);      // larger than all: head
    queue_order(sole_pkg::OP_ADD_BWD, 0, '0, 48'd1, 16'h0002);      // smaller than all: tail
    queue_order(sole_pkg::OP_ADD_FWD, 0, '0, 48'd2, 16'h0003);
    queue_order(sole_pkg::OP_ADD_BWD, 0, '1, 48'd2, 16'h0004);
    queue_order(sole_pkg::OP_UPDATE, 2, '1, '1, 16'hBEEF);          // update ignores owner
    queue_order(sole_pkg::OP_REMOVE, 1, '0, '0, 16'h0000);          // wrong owner
    queue_order(sole_pkg::OP_REMOVE, 1, '0, '0, 16'hFFFF);
    queue_order(sole_pkg::OP_REMOVE, 1, '0, '0, 16'hFFFF);          // already removed
    queue_order(sole_pkg::OP_UPDATE, 1, '0, '0, '0);                // update of removed slot
    queue_order(sole_pkg::OP_REMOVE, 8, '0, '0, '0);                // beyond slots used
    queue_order(sole_pkg::OP_REMOVE, 6, '0, '0, 16'h0002);
    queue_order(sole_pkg::OP_REMOVE, 4, '0, '0, 16'h0001, 1'b1);    // sender waits for drain
    // random: fill the pool, then keep going to reach pool-full behavior
    queue_session(300);
    queue_order(sole_pkg::OP_ADD_FWD, 0, rand_price(), '0, 16'h00AA, 1'b1);
    queue_session(200);
    // fill up with adds to hit pool full repeatedly
    for (k = 0; k < 70; k++)
      queue_order(k[0] ? sole_pkg::OP_ADD_BWD : sole_pkg::OP_ADD_FWD, 0, rand_price(), '1,
                  16'($urandom()));
    queue_session(160);
  end

  // Reset: held low from the start, released once.
  initial begin
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
  end

  // Driver: pop a beat, wait a random gap, present it until accepted.
  int in_gap = 0;
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_tvalid && in_tready) begin
        beats_in++;
        expected_resps = {expected_resps, apply_order(order_req_t'(in_tdata[120:0]))};
      end
      if (!(in_tvalid && !in_tready)) begin
        if (in_gap > 0) begin
          in_gap <= in_gap - 1;
          in_tvalid <= 1'b0;
        end else if (pending_orders.size() != 0 &&
                     !(hold_for_drain[0] &&
                       (expected_resps.size() != 0 || (in_tvalid && in_tready)))) begin
          in_tdata <= {7'b0, pending_orders.pop_front()};
          void'(hold_for_drain.pop_front());
          in_tvalid <= 1'b1;
          // no gap for one beat in four, else a random gap that may also be none
          in_gap <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 9);
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  // Monitor: random ready stalls, compare each result beat with the oldest prediction.
  int out_wait = 0;
  always @(posedge clk) begin
    order_resp_t got, want;
    if (rst_n) begin
      if (out_tvalid && out_tready) begin
        beats_out++;
        got = order_resp_t'(out_tdata[30:0]);
        if (expected_resps.size() == 0) begin
          $error("unexpected result beat %h", out_tdata);
          fail_count++;
        end else begin
          want = expected_resps.pop_front();
          if (got.status <= sole_pkg::ST_REMOVED) status_seen[got.status]++;
          if (got.status != want.status) begin
            $error("status: expected %0d, got %0d", want.status, got.status); fail_count++;
          end
          if (got.placed_slot != want.placed_slot) begin
            $error("placed_slot: expected %0d, got %0d", want.placed_slot, got.placed_slot);
            fail_count++;
          end
          if (got.head_slot != want.head_slot) begin
            $error("head_slot: expected %0d, got %0d", want.head_slot, got.head_slot);
            fail_count++;
          end
          if (got.tail_slot != want.tail_slot) begin
            $error("tail_slot: expected %0d, got %0d", want.tail_slot, got.tail_slot);
            fail_count++;
          end
          if (got.live_count != want.live_count) begin
            $error("live_count: expected %0d, got %0d", want.live_count, got.live_count);
            fail_count++;
          end
          if (out_tdata[31] !== 1'b0) begin
            $error("fill bit: expected 0, got %b", out_tdata[31]); fail_count++;
          end
        end
        out_wait <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 9);
        out_tready <= 1'b0;
      end else if (out_wait > 0) begin
        out_wait <= out_wait - 1;
        out_tready <= 1'b0;
      end else begin
        out_tready <= 1'b1;
      end
    end
  end

  // Watchdog and end of run.
  initial begin
    ol_head = 0; ol_tail = 0; ol_count = 0; ol_used = 0;
    wait (rst_n);
    forever begin
      @(posedge clk);
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) stall_cycles = 0;
      else stall_cycles++;
      if (stall_cycles >= WATCHDOG_LIMIT) begin
        $display("testbench: FAIL");
        $finish;
      end
      if (pending_orders.size() == 0 && !in_tvalid && beats_in > 0 &&
          expected_resps.size() == 0) begin
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (out_tvalid) begin
          $error("result beat after the last expected one");
          fail_count++;
        end
        $display("Ran %0d order beats, %0d results; ok %0d full %0d not-owner %0d",
                 beats_in, beats_out, status_seen[0], status_seen[1], status_seen[2]);
        $display("bad-slot %0d removed %0d; %0d slots handed out",
                 status_seen[3], status_seen[4], ol_used);
        if (fail_count == 0) $display("testbench: PASS");
        else $display("testbench: FAIL");
        $finish;
      end
    end
  end
endmodule

>>> files.f
hw/rtl/sole_pkg.sv
hw/rtl/sole_node_mem.sv
hw/rtl/sole_data_mem.sv
hw/rtl/sorted_order_list_engine_unit.sv
sim/testbench.sv
